@@ src/rrs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types, codes and constants of the round robin thread scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // default number of thread slots
  localparam int unsigned MaxSlotsDefault = 32;

  // field widths of the command and result words
  localparam int unsigned OpW     = 3;
  localparam int unsigned IdW     = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TStateW = 2;
  localparam int unsigned CountW  = 6;

  // operation codes (codes 6 and 7 are no-ops)
  typedef enum logic [OpW-1:0] {
    OP_CREATE   = 3'd0,
    OP_STOP     = 3'd1,
    OP_BLOCK    = 3'd2,
    OP_UNBLOCK  = 3'd3,
    OP_SCHEDULE = 3'd4,
    OP_QUERY    = 3'd5
  } rrs_op_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } rrs_status_e;

  // per-slot thread state
  typedef enum logic [TStateW-1:0] {
    TS_RUNNING    = 2'd0,
    TS_READY      = 2'd1,
    TS_BLOCKED    = 2'd2,
    TS_TERMINATED = 2'd3
  } rrs_tstate_e;

  // command word
  typedef struct packed {
    logic [OpW-1:0] operation;
    logic [IdW-1:0] thread_id;
  } rrs_req_t;

  // result word
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     result_thread;
    logic [TStateW-1:0] thread_state;
    logic [IdW-1:0]     running_thread;
    logic [CountW-1:0]  threads_in_use;
  } rrs_rsp_t;

endpackage

@@ src/rrs_ram.sv @@
// ----------------------------------------------------------------------------
// rrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrs_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/round_robin_thread_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// Per-slot thread state table with create, stop, block, unblock, query and a
// round robin schedule search stepped one slot per cycle.
// ----------------------------------------------------------------------------
//  channel  | ports                     | handshake
//  command  | start, busy, req_i        | taken when start high and busy low
//  result   | done_o, rsp_o             | one-cycle strobe, always taken
//
//  create, stop, block, no-op codes and unused-slot answers: result strobe
//  in the cycle after the command word is taken.
//  unblock and query of a slot in use: one read of the state table.
//  schedule: one table read per slot searched, at most threads_in_use slots;
//  the S_SC_WR state follows when the old thread goes back to ready.
//  after reset the block is ready at once; the result side cannot stall.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_top
  import rrs_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MaxSlotsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rrs_req_t req_i,
  output logic     done_o,
  output rrs_rsp_t rsp_o
);

  localparam int unsigned SlotW = $clog2(MAX_SLOTS);
  localparam int unsigned CntW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CmpW  = (CntW > IdW) ? CntW : IdW;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UNBLK  = 6'b000010,
    S_QUERY  = 6'b000100,
    S_SC_RUN = 6'b001000,
    S_SC_CHK = 6'b010000,
    S_SC_WR  = 6'b100000
  } rrs_fsm_e;

  rrs_fsm_e             state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [SlotW-1:0]     running_q, running_d;
  logic [SlotW-1:0]     id_q, id_d;
  logic [SlotW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]      n_q, n_d;
  logic [TStateW-1:0]   run_st_q, run_st_d;
  logic                 s0_wr_q, s0_wr_d;
  logic                 rd_zero_q, rd_zero_d;
  logic                 done_q, done_d;
  rrs_rsp_t             rsp_q, rsp_d;

  logic                 ram_we, ram_re;
  logic [SlotW-1:0]     ram_waddr, ram_raddr;
  logic [TStateW-1:0]   ram_wdata, ram_rdata, rd_val;

  logic [CmpW-1:0]      id_ext, cnt_ext;
  logic                 in_use;
  logic [SlotW-1:0]     id_slot, start_idx, idx_inc;
  logic [CntW-1:0]      run_inc, idx_wide_inc, n_inc;

  // state table
  rrs_ram #(
    .Width (TStateW),
    .Depth (MAX_SLOTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // slot 0 starts out running until its entry is first written
  assign rd_val = rd_zero_q ? TS_RUNNING : ram_rdata;

  // target slot decode
  assign id_ext  = CmpW'(req_i.thread_id);
  assign cnt_ext = CmpW'(count_q);
  assign in_use  = id_ext < cnt_ext;
  assign id_slot = id_ext[SlotW-1:0];

  // round robin wrap of the search index
  assign run_inc      = CntW'(running_q) + CntW'(1);
  assign start_idx    = (run_inc >= count_q) ? '0 : run_inc[SlotW-1:0];
  assign idx_wide_inc = CntW'(idx_q) + CntW'(1);
  assign idx_inc      = (idx_wide_inc >= count_q) ? '0 : idx_wide_inc[SlotW-1:0];
  assign n_inc        = n_q + CntW'(1);

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    running_d = running_q;
    id_d      = id_q;
    idx_d     = idx_q;
    n_d       = n_q;
    run_st_d  = run_st_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = id_slot;
    ram_wdata = TS_READY;
    ram_re    = 1'b0;
    ram_raddr = id_slot;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          rsp_d.status        = ST_OK;
          rsp_d.result_thread = '0;
          rsp_d.thread_state  = '0;
          unique case (req_i.operation) inside
            OP_CREATE: begin
              done_d = 1'b1;
              if (count_q >= CntW'(MAX_SLOTS)) begin
                rsp_d.status = ST_FULL;
              end else begin
                ram_we              = 1'b1;
                ram_waddr           = count_q[SlotW-1:0];
                ram_wdata           = TS_READY;
                count_d             = count_q + CntW'(1);
                rsp_d.result_thread = IdW'(count_q);
              end
            end
            OP_STOP, OP_BLOCK: begin
              done_d = 1'b1;
              if (in_use) begin
                ram_we    = 1'b1;
                ram_wdata = (req_i.operation == OP_STOP) ? TS_TERMINATED : TS_BLOCKED;
              end else begin
                rsp_d.status = ST_UNUSED;
              end
            end
            OP_UNBLOCK, OP_QUERY: begin
              if (in_use) begin
                ram_re  = 1'b1;
                id_d    = id_slot;
                state_d = (req_i.operation == OP_QUERY) ? S_QUERY : S_UNBLK;
              end else begin
                done_d       = 1'b1;
                rsp_d.status = ST_UNUSED;
              end
            end
            OP_SCHEDULE: begin
              ram_re    = 1'b1;
              ram_raddr = running_q;
              idx_d     = start_idx;
              n_d       = '0;
              state_d   = S_SC_RUN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_UNBLK: begin
        if (rd_val == TS_BLOCKED) begin
          ram_we    = 1'b1;
          ram_waddr = id_q;
          ram_wdata = TS_READY;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_QUERY: begin
        rsp_d.thread_state = rd_val;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end
      S_SC_RUN: begin
        run_st_d  = rd_val;
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (rd_val == TS_READY) begin
          if (run_st_q == TS_RUNNING) begin
            // old thread back to ready first
            ram_we    = 1'b1;
            ram_waddr = running_q;
            ram_wdata = TS_READY;
            state_d   = S_SC_WR;
          end else begin
            ram_we              = 1'b1;
            ram_waddr           = idx_q;
            ram_wdata           = TS_RUNNING;
            running_d           = idx_q;
            rsp_d.result_thread = IdW'(idx_q);
            done_d              = 1'b1;
            state_d             = S_IDLE;
          end
        end else if (n_inc >= count_q) begin
          // nothing ready: running slot stays
          rsp_d.result_thread = IdW'(running_q);
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end else begin
          idx_d     = idx_inc;
          n_d       = n_inc;
          ram_re    = 1'b1;
          ram_raddr = idx_inc;
        end
      end
      S_SC_WR: begin
        ram_we              = 1'b1;
        ram_waddr           = idx_q;
        ram_wdata           = TS_RUNNING;
        running_d           = idx_q;
        rsp_d.result_thread = IdW'(idx_q);
        done_d              = 1'b1;
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // running slot and count after the operation
    if (done_d) begin
      rsp_d.running_thread = IdW'(running_d);
      rsp_d.threads_in_use = CountW'(count_d);
    end
  end

  // slot 0 write tracking and read source
  assign s0_wr_d   = s0_wr_q | (ram_we && (ram_waddr == '0));
  assign rd_zero_d = ram_re ? ((ram_raddr == '0) && !s0_wr_q) : rd_zero_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= CntW'(1);
      running_q <= '0;
      s0_wr_q   <= 1'b0;
      rd_zero_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      running_q <= running_d;
      s0_wr_q   <= s0_wr_d;
      rd_zero_q <= rd_zero_d;
      done_q    <= done_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    idx_q    <= idx_d;
    n_q      <= n_d;
    run_st_q <= run_st_d;
    rsp_q    <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CntW'(MAX_SLOTS)))
    else $error("slot count out of range");

  a_running_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(running_q) < count_q)
    else $error("running slot not in use");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_create_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation == OP_CREATE)) |=> done_o)
    else $error("create did not answer in one cycle");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SC_CHK) |-> (n_q < count_q))
    else $error("schedule search ran past the slot count");

endmodule

@@ tb/round_robin_thread_scheduler_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top_test
// Self-checking bench for the thread scheduler. A directed run covers the
// corner cases and is followed by about a thousand random commands, with
// random gaps between command words. Every result word is compared field by
// field against a predicted thread table.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_top_test
  import rrs_pkg::*;
();

  localparam int unsigned NumSlots     = MaxSlotsDefault;
  localparam int unsigned RandomWords  = 1025;
  localparam int unsigned TailCycles   = 60;
  localparam realtime     RunLimit     = 10ms;

  // codes 6 and 7 are no-ops
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  // predicted thread table and queue of result words still to come
  class sched_scoreboard;
    rrs_tstate_e slot_st[NumSlots];
    int unsigned slot_count;
    int unsigned running;
    rrs_rsp_t    pending_results[$];
    int unsigned errors;

    function new();
      foreach (slot_st[i]) slot_st[i] = TS_TERMINATED;
      slot_st[0] = TS_RUNNING;
      slot_count = 1;
      running    = 0;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // round robin search from the slot after the running one
    function void pick_next();
      int unsigned idx;
      idx = running + 1;
      if (idx >= slot_count) idx = 0;
      for (int unsigned n = 0; n < slot_count; n++) begin
        if (slot_st[idx] == TS_READY) begin
          if (slot_st[running] == TS_RUNNING) slot_st[running] = TS_READY;
          slot_st[idx] = TS_RUNNING;
          running      = idx;
          return;
        end
        idx++;
        if (idx >= slot_count) idx = 0;
      end
    endfunction

    function rrs_rsp_t predict_result(rrs_req_t w);
      rrs_rsp_t    r;
      int unsigned id;
      bit          in_use;
      r      = '0;
      id     = w.thread_id;
      in_use = id < slot_count;
      case (w.operation)
        OP_CREATE: begin
          if (slot_count >= NumSlots) begin
            r.status = ST_FULL;
          end else begin
            slot_st[slot_count] = TS_READY;
            r.result_thread     = slot_count[IdW-1:0];
            slot_count++;
          end
        end
        OP_STOP: begin
          if (in_use) slot_st[id] = TS_TERMINATED;
          else r.status = ST_UNUSED;
        end
        OP_BLOCK: begin
          if (in_use) slot_st[id] = TS_BLOCKED;
          else r.status = ST_UNUSED;
        end
        OP_UNBLOCK: begin
          if (!in_use) r.status = ST_UNUSED;
          else if (slot_st[id] == TS_BLOCKED) slot_st[id] = TS_READY;
        end
        OP_SCHEDULE: begin
          pick_next();
          r.result_thread = running[IdW-1:0];
        end
        OP_QUERY: begin
          if (in_use) r.thread_state = slot_st[id];
          else r.status = ST_UNUSED;
        end
        default: ;
      endcase
      r.running_thread = running[IdW-1:0];
      r.threads_in_use = slot_count[CountW-1:0];
      return r;
    endfunction

    function void note_command(rrs_req_t w);
      pending_results.push_back(predict_result(w));
    endfunction

    task check_result(rrs_rsp_t got);
      rrs_rsp_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with nothing pending: %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.result_thread !== want.result_thread)
        report($sformatf("result_thread %0d, want %0d",
                         got.result_thread, want.result_thread));
      if (got.thread_state !== want.thread_state)
        report($sformatf("thread_state %0d, want %0d",
                         got.thread_state, want.thread_state));
      if (got.running_thread !== want.running_thread)
        report($sformatf("running_thread %0d, want %0d",
                         got.running_thread, want.running_thread));
      if (got.threads_in_use !== want.threads_in_use)
        report($sformatf("threads_in_use %0d, want %0d",
                         got.threads_in_use, want.threads_in_use));
    endtask
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rrs_req_t req_i;
  logic     done_o;
  rrs_rsp_t rsp_o;

  sched_scoreboard sb = new();
  int unsigned     quiet_left = 0;

  round_robin_thread_scheduler_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // watch both channels on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(rsp_o);
      if (start && !busy) sb.note_command(req_i);
    end
  end

  // mostly short gaps, a few long ones, and stretches with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one command word and hold it until the block takes it
  task automatic send(logic [OpW-1:0] op, logic [IdW-1:0] id);
    int unsigned gap;
    start           <= 1'b1;
    req_i.operation <= op;
    req_i.thread_id <= id;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random command: ids mostly inside the created range, unblock and
  // schedule heavy so the table keeps live threads, stop kept rare
  task automatic send_random();
    int unsigned    r;
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
    r = $urandom_range(0, 99);
    if (r < 8)       op = OP_CREATE;
    else if (r < 10) op = OP_STOP;
    else if (r < 25) op = OP_BLOCK;
    else if (r < 45) op = OP_UNBLOCK;
    else if (r < 73) op = OP_SCHEDULE;
    else if (r < 96) op = OP_QUERY;
    else if (r < 98) op = OpSpare6;
    else             op = OpSpare7;
    if (sb.slot_count >= NumSlots || $urandom_range(0, 99) < 80)
      id = IdW'($urandom_range(0, sb.slot_count - 1));
    else
      id = IdW'($urandom_range(sb.slot_count, NumSlots - 1));
    send(op, id);
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases
    send(OP_QUERY, 5'd0);
    send(OP_SCHEDULE, 5'd0);      // nothing ready, slot 0 stays
    send(OP_QUERY, 5'd31);        // unused slots
    send(OP_STOP, 5'd31);
    send(OP_BLOCK, 5'd5);
    send(OP_UNBLOCK, 5'd1);
    send(OpSpare6, 5'd17);
    send(OpSpare7, 5'd10);
    send(OP_CREATE, 5'd0);
    send(OP_CREATE, 5'd0);
    send(OP_UNBLOCK, 5'd1);       // ready slot, no change
    send(OP_SCHEDULE, 5'd0);
    send(OP_BLOCK, 5'd1);         // running slot blocked, stays running
    send(OP_SCHEDULE, 5'd0);      // old slot keeps blocked state
    send(OP_QUERY, 5'd1);
    send(OP_BLOCK, 5'd2);
    send(OP_STOP, 5'd0);
    send(OP_UNBLOCK, 5'd2);       // running slot made ready again
    send(OP_SCHEDULE, 5'd0);      // found last in the search
    send(OP_STOP, 5'd2);          // running slot stopped
    send(OP_SCHEDULE, 5'd0);      // nothing ready
    send(OP_QUERY, 5'd2);
    send(OP_UNBLOCK, 5'd1);
    send(OP_SCHEDULE, 5'd0);      // old slot stays terminated
    send(OP_QUERY, 5'd1);

    // random traffic, table fills part way through
    repeat (RandomWords) send_random();
    start <= 1'b0;
    @(posedge clk_i);

    // drain, then allow for a late or stray result word
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RunLimit);
    $display("simulation failed");
    $finish;
  end

endmodule
